[hdl/tlpw_pkg.sv]
package tlpw_pkg;

  // TLB geometry
  localparam int TLB_ENTRIES = 64;
  localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TLB_ENTRIES + 1);
  localparam int REM_W = $clog2(2 * TLB_ENTRIES);

  // Reciprocal for the victim modulo: floor(2^32 / TLB_ENTRIES)
  localparam logic [32:0] VIC_RECIP = 33'((64'd1 << 32) / TLB_ENTRIES);

  // Address split
  localparam int PAGE_SHIFT = 12;
  localparam int TAG_W = 32 - PAGE_SHIFT;
  localparam int BASE_W = 20;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 20;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGING = 1'b0,
    CFG_BASE   = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    FN_TRANSLATE = 1'b0,
    FN_RESPONSE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    K_READY = 2'd0,
    K_READ  = 2'd1,
    K_FAULT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DIR   = 2'd1,
    PH_TABLE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LOOKUP,
    S_HIT,
    S_VICTIM
  } state_t;

  // Commands into the tag array
  typedef struct packed {
    logic             flush;
    logic             wr;
    logic [IDX_W-1:0] slot;
  } cam_cmd_t;

  // Status out of the tag array
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic             full;
    logic [IDX_W-1:0] free_slot;
  } cam_stat_t;

  // Victim unit result
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] slot;
  } vic_res_t;

endpackage

[hdl/tlpw_in_if.sv]
interface tlpw_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] linear_address;
  logic [31:0] read_data;

  modport source (output valid, output func, output linear_address, output read_data,
                  input ready);
  modport sink (input valid, input func, input linear_address, input read_data,
                output ready);
endinterface

[hdl/tlpw_out_if.sv]
interface tlpw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] address;

  modport source (output valid, output kind, output address, input ready);
  modport sink (input valid, input kind, input address, output ready);
endinterface

[hdl/tlpw_frame_ram.sv]
module tlpw_frame_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [tlpw_pkg::IDX_W-1:0]  waddr,
  input  logic [tlpw_pkg::TAG_W-1:0]  wdata,
  input  logic                        re,
  input  logic [tlpw_pkg::IDX_W-1:0]  raddr,
  output logic [tlpw_pkg::TAG_W-1:0]  rdata
);

  logic [tlpw_pkg::TAG_W-1:0] mem [tlpw_pkg::TLB_ENTRIES];
  logic [tlpw_pkg::TAG_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/tlpw_tag_cam.sv]
module tlpw_tag_cam (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tlpw_pkg::TAG_W-1:0]  lookup_tag,
  input  logic [tlpw_pkg::TAG_W-1:0]  wr_tag,
  input  tlpw_pkg::cam_cmd_t          cmd,
  output tlpw_pkg::cam_stat_t         stat
);

  localparam int N = tlpw_pkg::TLB_ENTRIES;

  logic [tlpw_pkg::TAG_W-1:0] tag_r [N];
  logic [tlpw_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [N-1:0]               match;
  logic [tlpw_pkg::IDX_W-1:0] hit_idx;
  logic                       full;

  // Compare every live entry; entries fill in order, so live means below the count
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match[i] = (tlpw_pkg::CNT_W'(i) < count_r) && (tag_r[i] == lookup_tag);
    end
  end

  // Encode the (single) matching entry
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | tlpw_pkg::IDX_W'(i);
      end
    end
  end

  assign full = (count_r == tlpw_pkg::CNT_W'(N));

  always_comb begin
    stat.hit       = |match;
    stat.idx       = hit_idx;
    stat.full      = full;
    stat.free_slot = count_r[tlpw_pkg::IDX_W-1:0];
  end

  // Fill count: clear on flush, advance on an append
  always_comb begin
    count_nxt = count_r;
    if (cmd.flush) begin
      count_nxt = '0;
    end else if (cmd.wr && !full) begin
      count_nxt = count_r + tlpw_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Tag cells
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      tag_r[cmd.slot] <= wr_tag;
    end
  end

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(match))
    else $error("tag array holds duplicate live tags");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tlpw_pkg::CNT_W'(N))
    else $error("fill count beyond capacity");
  a_append_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr && !full |-> cmd.slot == count_r[tlpw_pkg::IDX_W-1:0])
    else $error("append not at first free entry");

endmodule

[hdl/tlpw_victim.sv]
module tlpw_victim (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output tlpw_pkg::vic_res_t  res
);

  localparam int N = tlpw_pkg::TLB_ENTRIES;

  logic [15:0]                lfsr_r;
  logic                       fb;
  logic                       v1_r, v2_r, v3_r;
  logic [48:0]                prod_r;
  logic [16:0]                quot;
  logic [31:0]                rem_full;
  logic [tlpw_pkg::REM_W-1:0] rem_r;

  // Advance the LFSR once per replacement
  assign fb = lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= tlpw_pkg::LFSR_SEED;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
    end else begin
      if (start) begin
        lfsr_r <= {fb, lfsr_r[15:1]};
      end
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Modulo by reciprocal: estimate quotient, subtract, then one correction
  assign quot     = prod_r[48:32];
  assign rem_full = 32'(lfsr_r) - (32'(quot) * 32'(N));

  always_ff @(posedge clk) begin
    prod_r <= 49'(lfsr_r) * 49'(tlpw_pkg::VIC_RECIP);
    rem_r  <= tlpw_pkg::REM_W'(rem_full);
  end

  always_comb begin
    res.done = v3_r;
    if (rem_r >= tlpw_pkg::REM_W'(N)) begin
      res.slot = tlpw_pkg::IDX_W'(rem_r - tlpw_pkg::REM_W'(N));
    end else begin
      res.slot = tlpw_pkg::IDX_W'(rem_r);
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r || v2_r) |-> !start)
    else $error("victim request while one is in flight");

endmodule

[hdl/two_level_page_walk_with_tlb_top.sv]
// Channel   Dir  Handshake        Payload
// in_ch     in   valid/ready      func, linear_address, read_data
// out_ch    out  valid/ready      kind, address
// cfg_*     in   cfg_we only      cfg_index, cfg_wdata
//
// Each item is accepted in S_IDLE, then decoded in S_DECODE; a response
// during a walk or a pass-through answers there. A translate request with
// paging on goes on to S_LOOKUP, which starts the walk on a miss, and on
// a hit to S_HIT after a frame RAM read. A fill that must replace waits in
// S_VICTIM on the victim modulo unit.
// Reset is synchronous; the TLB is empty after reset, no clearing pass.
// A stalled out_ch holds the block in any step that must answer until the
// result register frees.
module two_level_page_walk_with_tlb_top (
  input  logic                              clk,
  input  logic                              rst_n,
  tlpw_in_if.sink                           in_ch,
  tlpw_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [tlpw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tlpw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  tlpw_pkg::state_t    state_r, state_nxt;
  tlpw_pkg::phase_t    phase_r, phase_nxt;
  tlpw_pkg::cam_cmd_t  cam_cmd;
  tlpw_pkg::cam_stat_t cam_stat;
  tlpw_pkg::vic_res_t  vic_res;
  tlpw_pkg::kind_t     emit_kind;

  logic                              paging_r;
  logic [tlpw_pkg::BASE_W-1:0]       base_r;
  logic [tlpw_pkg::BASE_W-1:0]       last_base_r, last_base_nxt;
  logic [31:0]                       pend_r, pend_nxt;
  logic                              req_func_r;
  logic [31:0]                       req_lin_r;
  logic [31:0]                       req_data_r;
  logic                              out_valid_r, out_valid_nxt;
  logic [1:0]                        out_kind_r;
  logic [31:0]                       out_addr_r;
  logic                              in_acc;
  logic                              out_free;
  logic                              emit;
  logic [31:0]                       emit_addr;
  logic                              vic_start;
  logic                              ram_re;
  logic [tlpw_pkg::TAG_W-1:0]        frame_rd;
  logic                              present;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign present  = req_data_r[0];

  assign in_ch.ready   = (state_r == tlpw_pkg::S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.kind   = out_kind_r;
  assign out_ch.address = out_addr_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paging_r <= 1'b0;
      base_r   <= '0;
    end else if (cfg_we) begin
      unique case (tlpw_pkg::cfg_idx_t'(cfg_index))
        tlpw_pkg::CFG_PAGING: paging_r <= cfg_wdata[0];
        tlpw_pkg::CFG_BASE:   base_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_func_r <= in_ch.func;
      req_lin_r  <= in_ch.linear_address;
      req_data_r <= in_ch.read_data;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlpw_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = tlpw_pkg::S_DECODE;
        end
      end
      tlpw_pkg::S_DECODE: begin
        if (req_func_r == tlpw_pkg::FN_TRANSLATE) begin
          if (paging_r) begin
            state_nxt = tlpw_pkg::S_LOOKUP;
          end else if (out_free) begin
            state_nxt = tlpw_pkg::S_IDLE;
          end
        end else begin
          unique case (phase_r)
            tlpw_pkg::PH_DIR: begin
              if (out_free) begin
                state_nxt = tlpw_pkg::S_IDLE;
              end
            end
            tlpw_pkg::PH_TABLE: begin
              if (out_free) begin
                state_nxt = (present && cam_stat.full) ? tlpw_pkg::S_VICTIM
                                                       : tlpw_pkg::S_IDLE;
              end
            end
            default: state_nxt = tlpw_pkg::S_IDLE;
          endcase
        end
      end
      tlpw_pkg::S_LOOKUP: begin
        if (cam_stat.hit) begin
          state_nxt = tlpw_pkg::S_HIT;
        end else if (out_free) begin
          state_nxt = tlpw_pkg::S_IDLE;
        end
      end
      tlpw_pkg::S_HIT: begin
        if (out_free) begin
          state_nxt = tlpw_pkg::S_IDLE;
        end
      end
      tlpw_pkg::S_VICTIM: begin
        if (vic_res.done) begin
          state_nxt = tlpw_pkg::S_IDLE;
        end
      end
      default: state_nxt = tlpw_pkg::S_IDLE;
    endcase
  end

  // Outputs and walk bookkeeping
  always_comb begin
    emit          = 1'b0;
    emit_kind     = tlpw_pkg::K_READY;
    emit_addr     = req_lin_r;
    phase_nxt     = phase_r;
    pend_nxt      = pend_r;
    last_base_nxt = last_base_r;
    cam_cmd       = '0;
    vic_start     = 1'b0;
    ram_re        = 1'b0;
    unique case (state_r)
      tlpw_pkg::S_DECODE: begin
        if (req_func_r == tlpw_pkg::FN_TRANSLATE) begin
          phase_nxt = tlpw_pkg::PH_IDLE;
          if (!paging_r) begin
            emit = out_free;
          end else if (base_r != last_base_r) begin
            // Directory moved: drop every translation
            cam_cmd.flush = 1'b1;
            last_base_nxt = base_r;
          end
        end else begin
          unique case (phase_r)
            tlpw_pkg::PH_DIR: begin
              if (out_free) begin
                emit = 1'b1;
                if (present) begin
                  emit_kind = tlpw_pkg::K_READ;
                  emit_addr = {req_data_r[31:12], pend_r[21:12], 2'b00};
                  phase_nxt = tlpw_pkg::PH_TABLE;
                end else begin
                  emit_kind = tlpw_pkg::K_FAULT;
                  emit_addr = pend_r;
                  phase_nxt = tlpw_pkg::PH_IDLE;
                end
              end
            end
            tlpw_pkg::PH_TABLE: begin
              if (out_free) begin
                emit      = 1'b1;
                phase_nxt = tlpw_pkg::PH_IDLE;
                if (present) begin
                  emit_kind = tlpw_pkg::K_READY;
                  emit_addr = {req_data_r[31:12], pend_r[11:0]};
                  // Append to the first free entry, or pick a victim
                  if (cam_stat.full) begin
                    vic_start = 1'b1;
                  end else begin
                    cam_cmd.wr   = 1'b1;
                    cam_cmd.slot = cam_stat.free_slot;
                  end
                end else begin
                  emit_kind = tlpw_pkg::K_FAULT;
                  emit_addr = pend_r;
                end
              end
            end
            default: phase_nxt = tlpw_pkg::PH_IDLE;
          endcase
        end
      end
      tlpw_pkg::S_LOOKUP: begin
        if (cam_stat.hit) begin
          ram_re = 1'b1;
        end else if (out_free) begin
          // Miss: start the walk at the directory entry
          emit      = 1'b1;
          emit_kind = tlpw_pkg::K_READ;
          emit_addr = {base_r, req_lin_r[31:22], 2'b00};
          pend_nxt  = req_lin_r;
          phase_nxt = tlpw_pkg::PH_DIR;
        end
      end
      tlpw_pkg::S_HIT: begin
        emit      = out_free;
        emit_kind = tlpw_pkg::K_READY;
        emit_addr = {frame_rd, req_lin_r[11:0]};
      end
      tlpw_pkg::S_VICTIM: begin
        if (vic_res.done) begin
          cam_cmd.wr   = 1'b1;
          cam_cmd.slot = vic_res.slot;
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= emit_kind;
      out_addr_r <= emit_addr;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlpw_pkg::S_IDLE;
      phase_r     <= tlpw_pkg::PH_IDLE;
      pend_r      <= '0;
      last_base_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pend_r      <= pend_nxt;
      last_base_r <= last_base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  tlpw_tag_cam u_cam (
    .clk        (clk),
    .rst_n      (rst_n),
    .lookup_tag (req_lin_r[31:12]),
    .wr_tag     (pend_r[31:12]),
    .cmd        (cam_cmd),
    .stat       (cam_stat)
  );

  tlpw_frame_ram u_frame_ram (
    .clk   (clk),
    .we    (cam_cmd.wr),
    .waddr (cam_cmd.slot),
    .wdata (req_data_r[31:12]),
    .re    (ram_re),
    .raddr (cam_stat.idx),
    .rdata (frame_rd)
  );

  tlpw_victim u_victim (
    .clk   (clk),
    .rst_n (rst_n),
    .start (vic_start),
    .res   (vic_res)
  );

  a_hit_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tlpw_pkg::S_HIT |->
      $past(state_r) == tlpw_pkg::S_LOOKUP || $past(state_r) == tlpw_pkg::S_HIT)
    else $error("hit state entered without a lookup");
  a_victim_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    vic_res.done |-> state_r == tlpw_pkg::S_VICTIM)
    else $error("victim slot arrived outside the replace step");

endmodule
